// ===== design/fdcd_pkg.sv =====
// Package for the frame difference change detector.
// It holds the item types, the frame-store geometry, the gray weights and the register map.
// It depends on nothing else.
`timescale 1ns / 1ps

package fdcd_pkg;

   // Frame store depth; the pixel address wraps after the last entry.
   localparam int MAX_FRAME_PIXELS = 524288;
   localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);

   localparam int PIX_W   = 8;
   localparam int COUNT_W = 20;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // BGR to gray, fixed point over 2^14 with rounding.
   localparam int GRAY_FRAC = 14;
   localparam int PROD_W    = 22;
   localparam logic [PROD_W-1:0] WEIGHT_BLUE  = PROD_W'(1868);
   localparam logic [PROD_W-1:0] WEIGHT_GREEN = PROD_W'(9617);
   localparam logic [PROD_W-1:0] WEIGHT_RED   = PROD_W'(4899);
   localparam logic [PROD_W-1:0] GRAY_ROUND   = PROD_W'(8192);

   // Configuration register map.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANGE_PIXEL_LIMIT = 3'd0,
      CSR_DIFF_THRESHOLD     = 3'd1,
      CSR_STABLE_FRAMES      = 3'd2,
      CSR_PROCESSED_VALUE    = 3'd3,
      CSR_CAMERA_ID          = 3'd4
   } fdcd_csr_index_type;

   localparam logic [COUNT_W-1:0] RESET_CHANGE_PIXEL_LIMIT = COUNT_W'(921);
   localparam logic [PIX_W-1:0]   RESET_DIFF_THRESHOLD     = PIX_W'(20);
   localparam logic [7:0]         RESET_STABLE_FRAMES      = 8'd3;
   localparam logic               RESET_PROCESSED_VALUE    = 1'b0;
   localparam logic [7:0]         RESET_CAMERA_ID          = 8'd0;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             frame_end;
   } fdcd_req_type;

   typedef struct packed {
      logic       scene_changing;
      logic       scene_changed;
      logic       scene_processed;
      logic [7:0] camera_number;
   } fdcd_rsp_type;

   // End-of-frame event from the pixel path to the frame control.
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] count;
   } fdcd_frame_evt_type;

endpackage

// ===== design/frame_difference_change_detector.sv =====
// Top level of the frame difference change detector: configuration registers and
// the pixel path and frame control. Depends on fdcd_pkg, fdcd_pixel_path, fdcd_frame_ctrl.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake              Carries
//  req_     in         req_valid / req_ready  one BGR pixel item with its frame-end mark
//  rsp_     out        rsp_valid / rsp_ready  one result item per frame end with a change pending
//  csr_     in         csr_valid / csr_ready  register index and write data
//
// One pixel item is taken per cycle unless the pipeline stalls; the frame store is read at
// acceptance and written back as the item leaves stage one, so its single read and single
// write port set the rate. A frame-end item passes stage one and stage two before its
// result is registered in the output register. Reset is synchronous and clears the
// control state only: the frame store has no clearing pass and its contents are unknown
// until written. A result waiting in the output register stalls the pipeline only when
// another frame-end item reaches the count stage; ordinary pixels keep flowing.

module frame_difference_change_detector
   import fdcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fdcd_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fdcd_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers, always ready for a write.
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [PIX_W-1:0]   thresh_ff, thresh_in;
   logic [7:0]         stable_ff, stable_in;
   logic               processed_ff, processed_in;
   logic [7:0]         camera_ff, camera_in;

   fdcd_frame_evt_type evt;
   logic               evt_ready;

   assign csr_ready = 1'b1;

   // Writes to an index beyond the register map are dropped.
   always_comb begin
      limit_in     = limit_ff;
      thresh_in    = thresh_ff;
      stable_in    = stable_ff;
      processed_in = processed_ff;
      camera_in    = camera_ff;
      if (csr_valid) begin
         unique case (fdcd_csr_index_type'(csr_index))
            CSR_CHANGE_PIXEL_LIMIT: begin
               limit_in = csr_data[COUNT_W-1:0];
            end
            CSR_DIFF_THRESHOLD: begin
               thresh_in = csr_data[PIX_W-1:0];
            end
            CSR_STABLE_FRAMES: begin
               stable_in = csr_data[7:0];
            end
            CSR_PROCESSED_VALUE: begin
               processed_in = csr_data[0];
            end
            CSR_CAMERA_ID: begin
               camera_in = csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= RESET_CHANGE_PIXEL_LIMIT;
         thresh_ff    <= RESET_DIFF_THRESHOLD;
         stable_ff    <= RESET_STABLE_FRAMES;
         processed_ff <= RESET_PROCESSED_VALUE;
         camera_ff    <= RESET_CAMERA_ID;
      end else begin
         limit_ff     <= limit_in;
         thresh_ff    <= thresh_in;
         stable_ff    <= stable_in;
         processed_ff <= processed_in;
         camera_ff    <= camera_in;
      end
   end

   // Gray conversion, store read-modify-write and the per-frame count.
   fdcd_pixel_path u_pixel_path (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .diff_threshold (thresh_ff),
      .evt            (evt),
      .evt_ready      (evt_ready)
   );

   // Frame-end decision and the result register.
   fdcd_frame_ctrl u_frame_ctrl (
      .clock              (clock),
      .reset              (reset),
      .evt                (evt),
      .evt_ready          (evt_ready),
      .change_pixel_limit (limit_ff),
      .stable_frames      (stable_ff),
      .processed_value    (processed_ff),
      .camera_id          (camera_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data)
   );

endmodule

// ===== design/fdcd_pixel_path.sv =====
// Pixel path: gray conversion, frame store read-modify-write and changed-pixel count.
// Depends on fdcd_pkg.
`timescale 1ns / 1ps

module fdcd_pixel_path
   import fdcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fdcd_req_type       req_data,
   input  logic [PIX_W-1:0]   diff_threshold,
   output fdcd_frame_evt_type evt,
   input  logic               evt_ready
);

   logic [PIX_W-1:0] frame_mem [MAX_FRAME_PIXELS];

   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [PIX_W-1:0]   rd_data_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]  s1_pb_ff, s1_pg_ff, s1_pr_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_last_ff;
   logic               s1_hit_ff;
   logic [PIX_W-1:0]   s1_fwd_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic [PIX_W-1:0]   s2_gray_ff, s2_old_ff;
   logic               s2_last_ff;

   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic               accept, s1_adv, s2_adv;
   logic [PROD_W-1:0]  sum1;
   logic [PIX_W-1:0]   gray1, old1, diff2;
   logic               flag2;
   logic [COUNT_W-1:0] cnt_next;

   assign accept    = req_valid && req_ready;
   assign s2_adv    = s2_valid_ff && (!s2_last_ff || evt_ready);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_ready = !s1_valid_ff || s1_adv;

   // Stage one: sum the weighted components and pick the previous gray value.
   // A write to the same entry at the edge of the read is forwarded.
   assign sum1  = s1_pb_ff + s1_pg_ff + s1_pr_ff + GRAY_ROUND;
   assign gray1 = sum1[GRAY_FRAC +: PIX_W];
   assign old1  = s1_hit_ff ? s1_fwd_ff : rd_data_ff;

   always_comb begin
      if (req_data.frame_end) begin
         pos_in = '0;
      end else if (pos_ff == ADDR_W'(MAX_FRAME_PIXELS - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Stage two: absolute difference, threshold and saturating count.
   assign diff2    = (s2_gray_ff > s2_old_ff) ? (s2_gray_ff - s2_old_ff)
                                              : (s2_old_ff - s2_gray_ff);
   assign flag2    = diff2 > diff_threshold;
   assign cnt_next = (flag2 && (cnt_ff != COUNT_MAX)) ? (cnt_ff + 1'b1) : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (s2_adv) begin
         cnt_in = s2_last_ff ? '0 : cnt_next;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_adv);

   assign evt.done  = s2_valid_ff && s2_last_ff;
   assign evt.count = cnt_next;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= frame_mem[pos_ff];
      end
      if (s1_adv) begin
         frame_mem[s1_addr_ff] <= gray1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pb_ff   <= PROD_W'(req_data.blue)  * WEIGHT_BLUE;
         s1_pg_ff   <= PROD_W'(req_data.green) * WEIGHT_GREEN;
         s1_pr_ff   <= PROD_W'(req_data.red)   * WEIGHT_RED;
         s1_addr_ff <= pos_ff;
         s1_last_ff <= req_data.frame_end;
         s1_hit_ff  <= s1_adv && (s1_addr_ff == pos_ff);
         s1_fwd_ff  <= gray1;
      end
      if (s1_adv) begin
         s2_gray_ff <= gray1;
         s2_old_ff  <= old1;
         s2_last_ff <= s1_last_ff;
      end
   end

   // The next pixel after a frame end is stored from the start of the store.
   a_pos_restart : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.frame_end |=> pos_ff == '0)
      else $error("pixel address did not restart after a frame end");

   // Each frame starts its count afresh.
   a_count_clear : assert property (@(posedge clock) disable iff (reset)
      s2_adv && s2_last_ff |=> cnt_ff == '0)
      else $error("changed-pixel count not cleared at frame end");

endmodule

// ===== design/fdcd_frame_ctrl.sv =====
// Frame control: settle countdown, activity flag and the result output register.
// Depends on fdcd_pkg.
`timescale 1ns / 1ps

module fdcd_frame_ctrl
   import fdcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  fdcd_frame_evt_type evt,
   output logic               evt_ready,
   input  logic [COUNT_W-1:0] change_pixel_limit,
   input  logic [7:0]         stable_frames,
   input  logic               processed_value,
   input  logic [7:0]         camera_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fdcd_rsp_type       rsp_data
);

   logic         have_prev_ff, have_prev_in;
   logic         pending_ff, pending_in;
   logic [7:0]   countdown_ff, countdown_in;
   logic         rsp_valid_ff, rsp_valid_in;
   fdcd_rsp_type rsp_data_ff, rsp_data_in;

   logic         take, emit, pend_n;
   logic [7:0]   cd_n;

   assign evt_ready = !rsp_valid_ff || rsp_ready;
   assign take      = evt.done && evt_ready;

   always_comb begin
      pend_n = pending_ff;
      cd_n   = countdown_ff;
      if (evt.count > change_pixel_limit) begin
         pend_n = 1'b1;
         cd_n   = stable_frames;
      end else if (countdown_ff != '0) begin
         cd_n = countdown_ff - 1'b1;
      end
   end

   always_comb begin
      have_prev_in = have_prev_ff;
      pending_in   = pending_ff;
      countdown_in = countdown_ff;
      emit         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         have_prev_in = 1'b1;
         if (have_prev_ff) begin
            countdown_in = cd_n;
            pending_in   = pend_n;
            if (pend_n) begin
               emit                      = 1'b1;
               rsp_data_in.camera_number = camera_id;
               if (cd_n == '0) begin
                  pending_in                  = 1'b0;
                  rsp_data_in.scene_changing  = 1'b0;
                  rsp_data_in.scene_changed   = 1'b1;
                  rsp_data_in.scene_processed = processed_value;
               end else begin
                  rsp_data_in.scene_changing  = 1'b1;
                  rsp_data_in.scene_changed   = 1'b0;
                  rsp_data_in.scene_processed = 1'b0;
               end
            end
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         pending_ff   <= 1'b0;
         countdown_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         pending_ff   <= pending_in;
         countdown_ff <= countdown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A result reports either changing or changed, never both.
   a_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.scene_changing && rsp_data_ff.scene_changed))
      else $error("result reports changing and changed at once");

   // Reporting a settled scene ends the pending activity.
   a_settle_clears : assert property (@(posedge clock) disable iff (reset)
      emit && rsp_data_in.scene_changed |=> !pending_ff)
      else $error("activity still pending after a settled result");

   // The first frame only primes the store and never gives a result.
   a_first_frame : assert property (@(posedge clock) disable iff (reset)
      take && !have_prev_ff |-> !emit)
      else $error("result on the first frame");

endmodule
